FILE: rtl/ialist_pkg.sv
// ----------------------------------------------------------------------------
// Indexed array list package
// Shared types and constants for the list engine and its storage cells.
// ----------------------------------------------------------------------------
package ialist_pkg;

	localparam int DEFAULT_DEPTH      = 64;
	localparam int DEFAULT_DATA_WIDTH = 32;
	// Wide enough for a cell index at the largest supported depth.
	localparam int CMD_POS_W          = 13;

	typedef enum logic [2:0] {
		ACT_APPEND     = 3'd0,
		ACT_INSERT     = 3'd1,
		ACT_UPDATE     = 3'd2,
		ACT_DEL_VALUE  = 3'd3,
		ACT_DEL_INDEX  = 3'd4,
		ACT_CLEAR      = 3'd5,
		ACT_READ       = 3'd6
	} action_t;

	typedef enum logic [2:0] {
		STS_OK        = 3'd0,
		STS_RANGE     = 3'd1,
		STS_FULL      = 3'd2,
		STS_NOT_FOUND = 3'd3,
		STS_EMPTY     = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		CMD_HOLD       = 2'd0,
		CMD_WRITE      = 2'd1,
		CMD_SHIFT_UP   = 2'd2,
		CMD_SHIFT_DOWN = 2'd3
	} cell_op_t;

	typedef struct packed {
		cell_op_t               op;
		logic [CMD_POS_W-1:0]   pos;
	} cell_cmd_t;

endpackage

FILE: rtl/ialist_cell.sv
// ----------------------------------------------------------------------------
// Indexed array list cell
// Holds one list entry and moves it to or from its neighbors on command.
// ----------------------------------------------------------------------------
module ialist_cell import ialist_pkg::*; #(
	parameter int DATA_WIDTH = DEFAULT_DATA_WIDTH,
	parameter int INDEX      = 0
) (
	input  logic                  clk,
	input  cell_cmd_t             cmd,
	input  logic [DATA_WIDTH-1:0] cmd_value,
	input  logic [DATA_WIDTH-1:0] prev_word,
	input  logic [DATA_WIDTH-1:0] next_word,
	output logic [DATA_WIDTH-1:0] word,
	output logic                  match
);

	localparam logic [CMD_POS_W-1:0] MY_POS = CMD_POS_W'(INDEX);

	logic [DATA_WIDTH-1:0] word_q;
	logic                  match_q;

	always_ff @(posedge clk) begin
		match_q <= (word_q == cmd_value);
		unique case (cmd.op)
			CMD_HOLD: begin
				word_q <= word_q;
			end
			CMD_WRITE: begin
				if (cmd.pos == MY_POS) begin
					word_q <= cmd_value;
				end
			end
			CMD_SHIFT_UP: begin
				if (cmd.pos == MY_POS) begin
					word_q <= cmd_value;
				end else if (cmd.pos < MY_POS) begin
					word_q <= prev_word;
				end
			end
			CMD_SHIFT_DOWN: begin
				if (cmd.pos <= MY_POS) begin
					word_q <= next_word;
				end
			end
		endcase
	end

	assign word  = word_q;
	assign match = match_q;

endmodule

FILE: rtl/indexed_array_list_engine.sv
// ----------------------------------------------------------------------------
// Indexed array list engine
// Ordered list of words kept in a chain of cells, with append, insert,
// update, delete by value or index, clear and read requests.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                 Beat contents
// request   in         start high, busy low      action, position, value, repeat_req
// result    out        done high for one cycle   status, read_value, list_length
//
// Append, update, delete by index, clear, read and any request that fails its
// index, full or empty check return their result in the cycle after the request
// beat. An insert that goes ahead shifts the chain once per copy in repeat_req,
// one place per cycle. Delete by value on a non-empty list first has the cells
// compare, then a scan walks down one cell per cycle. Reset clears the control
// state and length, not the cells; results cannot be stalled.
// ----------------------------------------------------------------------------
module indexed_array_list_engine import ialist_pkg::*; #(
	parameter int DEPTH      = DEFAULT_DEPTH,
	parameter int DATA_WIDTH = DEFAULT_DATA_WIDTH,
	localparam int IDX_W     = $clog2(DEPTH + 1)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [2:0]                   action,
	input  logic [IDX_W-1:0]             position,
	input  logic signed [DATA_WIDTH-1:0] value,
	input  logic [IDX_W-1:0]             repeat_req,
	output logic                         done,
	output logic [2:0]                   status,
	output logic signed [DATA_WIDTH-1:0] read_value,
	output logic [IDX_W-1:0]             list_length
);

	localparam int ADDR_W = $clog2(DEPTH);

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_INSERT = 3'b010,
		S_SCAN   = 3'b100
	} state_t;

	state_t                state_q, state_d;
	logic [IDX_W-1:0]      len_q, len_d;
	logic [IDX_W-1:0]      rep_q, rep_d;
	logic [IDX_W-1:0]      pos_q;
	logic [DATA_WIDTH-1:0] value_q;
	logic [ADDR_W-1:0]     scan_q, scan_d;

	logic                  done_q;
	status_t               status_q;
	logic [DATA_WIDTH-1:0] read_value_q;
	logic [IDX_W-1:0]      list_length_q;

	cell_cmd_t             cmd;
	logic [DATA_WIDTH-1:0] cmd_value;
	logic [DATA_WIDTH-1:0] words [DEPTH];
	logic [DEPTH-1:0]      match_vec;

	logic                  accept;
	logic                  fin;
	status_t               fin_status;
	logic [DATA_WIDTH-1:0] fin_rd;
	logic [IDX_W:0]        ins_total;

	assign busy      = (state_q != S_IDLE);
	assign accept    = start && !busy;
	assign cmd_value = busy ? value_q : value;
	assign ins_total = {1'b0, len_q} + {1'b0, repeat_req};

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] prev_w;
		logic [DATA_WIDTH-1:0] next_w;

		if (i == 0) begin : g_first
			assign prev_w = '0;
		end else begin : g_mid_lo
			assign prev_w = words[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign next_w = '0;
		end else begin : g_mid_hi
			assign next_w = words[i+1];
		end

		ialist_cell #(
			.DATA_WIDTH (DATA_WIDTH),
			.INDEX      (i)
		) u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.cmd_value (cmd_value),
			.prev_word (prev_w),
			.next_word (next_w),
			.word      (words[i]),
			.match     (match_vec[i])
		);
	end

	always_comb begin
		state_d    = state_q;
		len_d      = len_q;
		rep_d      = rep_q;
		scan_d     = scan_q;
		cmd.op     = CMD_HOLD;
		cmd.pos    = '0;
		fin        = 1'b0;
		fin_status = STS_OK;
		fin_rd     = '0;

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (action_t'(action))
						ACT_APPEND: begin
							fin = 1'b1;
							if (len_q == IDX_W'(DEPTH)) begin
								fin_status = STS_FULL;
							end else begin
								cmd.op  = CMD_WRITE;
								cmd.pos = CMD_POS_W'(len_q);
								len_d   = len_q + 1'b1;
							end
						end
						ACT_INSERT: begin
							if (position > len_q) begin
								fin        = 1'b1;
								fin_status = STS_RANGE;
							end else if (ins_total > (IDX_W + 1)'(DEPTH)) begin
								fin        = 1'b1;
								fin_status = STS_FULL;
							end else if (repeat_req == '0) begin
								fin = 1'b1;
							end else begin
								rep_d   = repeat_req;
								state_d = S_INSERT;
							end
						end
						ACT_UPDATE: begin
							fin = 1'b1;
							if (position >= len_q) begin
								fin_status = STS_RANGE;
							end else begin
								cmd.op  = CMD_WRITE;
								cmd.pos = CMD_POS_W'(position);
							end
						end
						ACT_DEL_VALUE: begin
							if (len_q == '0) begin
								fin        = 1'b1;
								fin_status = STS_EMPTY;
							end else begin
								scan_d  = ADDR_W'(len_q - 1'b1);
								state_d = S_SCAN;
							end
						end
						ACT_DEL_INDEX: begin
							fin = 1'b1;
							if (len_q == '0) begin
								fin_status = STS_EMPTY;
							end else if (position >= len_q) begin
								fin_status = STS_RANGE;
							end else begin
								cmd.op  = CMD_SHIFT_DOWN;
								cmd.pos = CMD_POS_W'(position);
								len_d   = len_q - 1'b1;
							end
						end
						ACT_CLEAR: begin
							fin   = 1'b1;
							len_d = '0;
						end
						ACT_READ: begin
							fin = 1'b1;
							if (position >= len_q) begin
								fin_status = STS_RANGE;
							end else begin
								fin_rd = words[position[ADDR_W-1:0]];
							end
						end
						default: begin
							fin = 1'b1;
						end
					endcase
				end
			end
			S_INSERT: begin
				cmd.op  = CMD_SHIFT_UP;
				cmd.pos = CMD_POS_W'(pos_q);
				len_d   = len_q + 1'b1;
				rep_d   = rep_q - 1'b1;
				if (rep_q == IDX_W'(1)) begin
					fin     = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_SCAN: begin
				if (match_vec[scan_q]) begin
					cmd.op  = CMD_SHIFT_DOWN;
					cmd.pos = CMD_POS_W'(scan_q);
					len_d   = len_q - 1'b1;
					fin     = 1'b1;
					state_d = S_IDLE;
				end else if (scan_q == '0) begin
					fin        = 1'b1;
					fin_status = STS_NOT_FOUND;
					state_d    = S_IDLE;
				end else begin
					scan_d = scan_q - 1'b1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			len_q   <= '0;
			rep_q   <= '0;
			scan_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			len_q   <= len_d;
			rep_q   <= rep_d;
			scan_q  <= scan_d;
			done_q  <= fin;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pos_q   <= position;
			value_q <= value;
		end
		if (fin) begin
			status_q      <= fin_status;
			read_value_q  <= fin_rd;
			list_length_q <= len_d;
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign read_value  = read_value_q;
	assign list_length = list_length_q;

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= IDX_W'(DEPTH))
		else $error("list length exceeds depth");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy)
		else $error("result beat while a request is still in progress");

	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done_q))
		else $error("accepted request neither in progress nor finished");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INSERT) |-> (rep_q != '0))
		else $error("insert in progress with no copies left");

endmodule

FILE: tb/sv/indexed_array_list_engine_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Indexed array list engine testbench
// Drives list requests through the start/busy handshake and checks every
// result beat against a behavioral copy of the list kept in the bench. A
// directed table covers the empty and full list, the range and not-found
// cases, the extreme words and the unused action code. Random phases with
// varying sender gaps follow.
// ----------------------------------------------------------------------------
module indexed_array_list_engine_tb import ialist_pkg::*;;

	localparam int DEPTH      = 64;
	localparam int WORD_W     = 32;
	localparam int IDX_W      = 7;
	localparam int STALL_MAX  = 2000;
	localparam int N_PLAN     = 25;
	localparam int N_PHASES   = 4;
	localparam int PHASE_ITEMS = 132;

	typedef struct {
		status_t                   status;
		logic signed [WORD_W-1:0]  rd;
		logic [IDX_W-1:0]          len;
	} list_result_t;

	typedef struct {
		logic [2:0]                act;
		logic [IDX_W-1:0]          pos;
		logic signed [WORD_W-1:0]  val;
		logic [IDX_W-1:0]          rep;
		bit                        typed;
		status_t                   status;
		logic signed [WORD_W-1:0]  rd;
		logic [IDX_W-1:0]          len;
	} plan_row_t;

	logic                      clk;
	logic                      arst_n;
	logic                      start;
	logic                      busy;
	logic [2:0]                action;
	logic [IDX_W-1:0]          position;
	logic signed [WORD_W-1:0]  value;
	logic [IDX_W-1:0]          repeat_req;
	logic                      done;
	logic [2:0]                status;
	logic signed [WORD_W-1:0]  read_value;
	logic [IDX_W-1:0]          list_length;

	logic signed [WORD_W-1:0]  list_mem [DEPTH];
	int                        list_len;
	list_result_t              pending_q [$];
	plan_row_t                 plan [N_PLAN];
	int                        gap_pct;
	int                        mismatches;
	int                        n_requests;
	int                        n_checked;
	int                        longest;
	int                        n_full;
	int                        n_not_found;
	int                        quiet_cycles;

	indexed_array_list_engine #(
		.DEPTH(DEPTH),
		.DATA_WIDTH(WORD_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.action(action),
		.position(position),
		.value(value),
		.repeat_req(repeat_req),
		.done(done),
		.status(status),
		.read_value(read_value),
		.list_length(list_length)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic void drop_entry(int idx);
		for (int i = idx; i + 1 < list_len; i++)
			list_mem[i] = list_mem[i + 1];
		list_len--;
	endfunction

	function automatic list_result_t apply_request(logic [2:0] act, int pos,
			logic signed [WORD_W-1:0] val, int rep);
		list_result_t r;
		int hit_at;
		r.status = STS_OK;
		r.rd = '0;
		case (act)
			ACT_APPEND: begin
				if (list_len >= DEPTH) begin
					r.status = STS_FULL;
				end else begin
					list_mem[list_len] = val;
					list_len++;
				end
			end
			ACT_INSERT: begin
				if (pos > list_len) begin
					r.status = STS_RANGE;
				end else if (list_len + rep > DEPTH) begin
					r.status = STS_FULL;
				end else if (rep != 0) begin
					for (int i = list_len; i > pos; i--)
						list_mem[i - 1 + rep] = list_mem[i - 1];
					for (int i = 0; i < rep; i++)
						list_mem[pos + i] = val;
					list_len += rep;
				end
			end
			ACT_UPDATE: begin
				if (pos >= list_len)
					r.status = STS_RANGE;
				else
					list_mem[pos] = val;
			end
			ACT_DEL_VALUE: begin
				if (list_len == 0) begin
					r.status = STS_EMPTY;
				end else begin
					// The last matching entry is the one removed.
					hit_at = -1;
					for (int i = 0; i < list_len; i++)
						if (list_mem[i] == val)
							hit_at = i;
					if (hit_at < 0)
						r.status = STS_NOT_FOUND;
					else
						drop_entry(hit_at);
				end
			end
			ACT_DEL_INDEX: begin
				if (list_len == 0)
					r.status = STS_EMPTY;
				else if (pos >= list_len)
					r.status = STS_RANGE;
				else
					drop_entry(pos);
			end
			ACT_CLEAR: begin
				list_len = 0;
			end
			ACT_READ: begin
				if (pos >= list_len)
					r.status = STS_RANGE;
				else
					r.rd = list_mem[pos];
			end
			default: begin
			end
		endcase
		r.len = IDX_W'(list_len);
		return r;
	endfunction

	task automatic issue(plan_row_t row);
		list_result_t predicted;
		if ($urandom_range(0, 99) < gap_pct) begin
			do begin
				@(negedge clk);
				start <= 1'b0;
			end while ($urandom_range(0, 99) < gap_pct);
		end
		@(negedge clk);
		start      <= 1'b1;
		action     <= row.act;
		position   <= row.pos;
		value      <= row.val;
		repeat_req <= row.rep;
		do
			@(posedge clk);
		while (busy);
		predicted = apply_request(row.act, int'(row.pos), row.val, int'(row.rep));
		if (row.typed) begin
			predicted.status = row.status;
			predicted.rd = row.rd;
			predicted.len = row.len;
		end
		pending_q.push_back(predicted);
		n_requests++;
		if (list_len > longest)
			longest = list_len;
	endtask

	task automatic drain_results();
		@(negedge clk);
		start <= 1'b0;
		while (pending_q.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic signed [WORD_W-1:0] pick_word();
		int r;
		r = $urandom_range(0, 19);
		if (r < 12)
			return WORD_W'($urandom_range(0, 7));
		else if (r < 14)
			return -WORD_W'($urandom_range(1, 4));
		else if (r < 17)
			return $urandom;
		else if (r < 18)
			return 32'sh7FFF_FFFF;
		else if (r < 19)
			return 32'sh8000_0000;
		return 32'sh0000_0000;
	endfunction

	function automatic plan_row_t random_row();
		plan_row_t row;
		int r;
		r = $urandom_range(0, 99);
		if (r < 18)
			row.act = ACT_APPEND;
		else if (r < 33)
			row.act = ACT_INSERT;
		else if (r < 44)
			row.act = ACT_UPDATE;
		else if (r < 58)
			row.act = ACT_DEL_VALUE;
		else if (r < 72)
			row.act = ACT_DEL_INDEX;
		else if (r < 75)
			row.act = ACT_CLEAR;
		else if (r < 99)
			row.act = ACT_READ;
		else
			row.act = 3'd7;
		if ($urandom_range(0, 99) < 85)
			row.pos = IDX_W'($urandom_range(0, list_len));
		else
			row.pos = IDX_W'($urandom_range(0, DEPTH));
		row.val = pick_word();
		r = $urandom_range(0, 99);
		if (r < 70)
			row.rep = IDX_W'($urandom_range(1, 4));
		else if (r < 90)
			row.rep = IDX_W'($urandom_range(5, 20));
		else if (r < 98)
			row.rep = IDX_W'($urandom_range(21, DEPTH));
		else
			row.rep = '0;
		row.typed = 1'b0;
		row.status = STS_OK;
		row.rd = '0;
		row.len = '0;
		return row;
	endfunction

	always @(posedge clk) begin
		list_result_t want;
		if (arst_n && done) begin
			n_checked++;
			if (pending_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%t: unexpected beat: status %0d value %0d length %0d",
						$realtime, status, read_value, list_length);
			end else begin
				want = pending_q.pop_front();
				if (want.status == STS_FULL)
					n_full++;
				if (want.status == STS_NOT_FOUND)
					n_not_found++;
				if (status !== want.status || read_value !== want.rd ||
						list_length !== want.len) begin
					mismatches++;
					if (mismatches <= 10)
						$display(
							"%t: expected %0d/%0d/%0d, got %0d/%0d/%0d",
							$realtime, want.status, want.rd, want.len,
							status, read_value, list_length);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || done || (start && !busy)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_MAX) begin
			$display("%t: no handshake for %0d cycles", $realtime, STALL_MAX);
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		start = 1'b0;
		action = ACT_APPEND;
		position = '0;
		value = '0;
		repeat_req = '0;
		arst_n = 1'b0;
		list_len = 0;
		gap_pct = 0;
		mismatches = 0;
		n_requests = 0;
		n_checked = 0;
		longest = 0;
		n_full = 0;
		n_not_found = 0;
		quiet_cycles = 0;
		for (int i = 0; i < DEPTH; i++)
			list_mem[i] = '0;

		plan = '{
			'{ACT_READ,      7'd0,  32'sd0,         7'd1,  1'b1, STS_RANGE,     32'sd0, 7'd0},
			'{ACT_DEL_VALUE, 7'd0,  32'sd0,         7'd1,  1'b1, STS_EMPTY,     32'sd0, 7'd0},
			'{ACT_DEL_INDEX, 7'd0,  32'sd0,         7'd1,  1'b1, STS_EMPTY,     32'sd0, 7'd0},
			'{ACT_UPDATE,    7'd0,  32'sd3,         7'd1,  1'b1, STS_RANGE,     32'sd0, 7'd0},
			'{ACT_INSERT,    7'd1,  32'sd3,         7'd1,  1'b1, STS_RANGE,     32'sd0, 7'd0},
			'{ACT_INSERT,    7'd0,  32'sh7FFF_FFFF, 7'd64, 1'b1, STS_OK,        32'sd0, 7'd64},
			'{ACT_APPEND,    7'd0,  32'sd1,         7'd1,  1'b1, STS_FULL,      32'sd0, 7'd64},
			'{ACT_INSERT,    7'd64, 32'sd1,         7'd1,  1'b1, STS_FULL,      32'sd0, 7'd64},
			'{ACT_READ,      7'd63, 32'sd0,         7'd1,  1'b1, STS_OK,
				32'sh7FFF_FFFF, 7'd64},
			'{ACT_READ,      7'd64, 32'sd0,         7'd1,  1'b1, STS_RANGE,     32'sd0, 7'd64},
			'{ACT_CLEAR,     7'd0,  32'sd0,         7'd1,  1'b1, STS_OK,        32'sd0, 7'd0},
			'{ACT_APPEND,    7'd0,  32'sh8000_0000, 7'd1,  1'b1, STS_OK,        32'sd0, 7'd1},
			'{ACT_APPEND,    7'd0,  32'sd0,         7'd1,  1'b1, STS_OK,        32'sd0, 7'd2},
			'{ACT_INSERT,    7'd1,  -32'sd1,        7'd0,  1'b1, STS_OK,        32'sd0, 7'd2},
			'{ACT_INSERT,    7'd2,  32'sd5,         7'd3,  1'b1, STS_OK,        32'sd0, 7'd5},
			'{ACT_INSERT,    7'd0,  32'sd7,         7'd2,  1'b1, STS_OK,        32'sd0, 7'd7},
			'{ACT_UPDATE,    7'd6,  32'sd9,         7'd1,  1'b1, STS_OK,        32'sd0, 7'd7},
			'{ACT_DEL_VALUE, 7'd0,  32'sd12345,     7'd1,  1'b1, STS_NOT_FOUND, 32'sd0, 7'd7},
			'{ACT_DEL_VALUE, 7'd0,  32'sd5,         7'd1,  1'b1, STS_OK,        32'sd0, 7'd6},
			'{ACT_READ,      7'd0,  32'sd0,         7'd1,  1'b0, STS_OK,        32'sd0, 7'd0},
			'{ACT_DEL_INDEX, 7'd6,  32'sd0,         7'd1,  1'b1, STS_RANGE,     32'sd0, 7'd6},
			'{ACT_DEL_INDEX, 7'd0,  32'sd0,         7'd1,  1'b1, STS_OK,        32'sd0, 7'd5},
			'{ACT_READ,      7'd4,  32'sd0,         7'd1,  1'b0, STS_OK,        32'sd0, 7'd0},
			'{3'd7,          7'd3,  32'sd1,         7'd1,  1'b1, STS_OK,        32'sd0, 7'd5},
			'{ACT_READ,      7'd1,  32'sd0,         7'd1,  1'b0, STS_OK,        32'sd0, 7'd0}
		};

		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		foreach (plan[i])
			issue(plan[i]);
		drain_results();

		for (int ph = 0; ph < N_PHASES; ph++) begin
			case (ph)
				1: gap_pct = 77;
				2: gap_pct = 35;
				default: gap_pct = 0;
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++)
				issue(random_row());
			// Hold the request side off until every beat is back.
			drain_results();
		end

		repeat (80) @(posedge clk);
		$display("Ran %0d requests (%0d from the table), checked %0d result beats.",
			n_requests, N_PLAN, n_checked);
		$display("Longest list %0d entries; %0d full and %0d not-found results seen.",
			longest, n_full, n_not_found);
		if (mismatches == 0 && pending_q.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

FILE: sim.f
rtl/ialist_pkg.sv
rtl/ialist_cell.sv
rtl/indexed_array_list_engine.sv
tb/sv/indexed_array_list_engine_tb.sv
